/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the codec modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FPSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FPSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/fpsd_pkg.sv */
// Types and constants shared by the float plane split delta codec.
package fpsd_pkg;

   localparam int COUNT_W     = 13;
   localparam int PLANES      = 3;
   localparam int TDATA_W     = 72;
   localparam int QUEUE_DEPTH = 2;

   localparam int SIGN_BIT = 31;
   localparam int EXP_LSB  = 23;
   localparam int HIGH_LSB = 16;
   localparam int MID_LSB  = 8;

   localparam logic [7:0] HIGH_MASK = 8'h7f;
   localparam logic [7:0] BYTE_MASK = 8'hff;

   // Plane order inside the predictor arrays.
   localparam int PLANE_HIGH = 0;
   localparam int PLANE_MID  = 1;
   localparam int PLANE_LOW  = 2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [1:0] REG_MODE         = 2'd0;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
   localparam logic [1:0] REG_ROW_COUNT    = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [COUNT_W-1:0] column_count;
      logic [COUNT_W-1:0] row_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] float_bits;
      logic        sign_in;
      logic [7:0]  exponent_in;
      logic [7:0]  delta_high_in;
      logic [7:0]  delta_mid_in;
      logic [7:0]  delta_low_in;
   } item_type;

   // One classified cell as it travels from the front to the back.
   typedef struct packed {
      item_type item;
      logic     mode;
      logic     first_col;
      logic     last;
   } cell_type;

   typedef struct packed {
      logic [31:0] float_out;
      logic        sign_out;
      logic [7:0]  exponent_out;
      logic [7:0]  delta_high_out;
      logic [7:0]  delta_mid_out;
      logic [7:0]  delta_low_out;
      logic        tile_last;
   } rsp_type;

endpackage

/* hw/rtl/fpsd_front.sv */
// Front end: accepts cells, tracks the tile position and classifies each cell.
module fpsd_front #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  fpsd_pkg::cfg_type  cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  fpsd_pkg::item_type item,
   input  logic               queue_full,
   output logic               push,
   output fpsd_pkg::cell_type push_cell
);

   localparam int IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int EFF_W = $clog2(MAX_DIMENSION + 1);
   localparam int CMP_W = ((EFF_W > fpsd_pkg::COUNT_W) ? EFF_W : fpsd_pkg::COUNT_W) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DIMENSION);

   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0] cols_eff, rows_eff;
   logic             first_col, last_col, last_row, last;

   // A count of zero acts as one and a count above the limit acts as the limit.
   function automatic logic [CMP_W-1:0] clamp_count(input logic [fpsd_pkg::COUNT_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0) begin
         return CMP_W'(1);
      end else if (ext > MAX_CMP) begin
         return MAX_CMP;
      end
      return ext;
   endfunction

   assign cols_eff  = clamp_count(cfg.column_count);
   assign rows_eff  = clamp_count(cfg.row_count);
   assign first_col = (col_ff == '0);
   assign last_col  = (CMP_W'(col_ff) + CMP_W'(1)) >= cols_eff;
   assign last_row  = (CMP_W'(row_ff) + CMP_W'(1)) >= rows_eff;
   assign last      = last_col && last_row;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   assign push_cell.item      = item;
   assign push_cell.mode      = cfg.mode;
   assign push_cell.first_col = first_col;
   assign push_cell.last      = last;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* hw/rtl/fpsd_queue.sv */
// Short queue of classified cells between the front and the back.
`include "assert_macros.svh"

module fpsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fpsd_pkg::cell_type push_cell,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output fpsd_pkg::cell_type pop_cell
);

   localparam int PTR_W = (fpsd_pkg::QUEUE_DEPTH > 1) ? $clog2(fpsd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(fpsd_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(fpsd_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(fpsd_pkg::QUEUE_DEPTH - 1);

   fpsd_pkg::cell_type entry_ff [fpsd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_cell  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cell;
      end
   end

   `FPSD_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !full)
   `FPSD_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, pop_valid)

endmodule

/* hw/rtl/fpsd_back.sv */
// Back end: delta codes the three mantissa planes and holds the result register.
`include "assert_macros.svh"

module fpsd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  fpsd_pkg::cell_type pop_cell,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output fpsd_pkg::rsp_type  rsp
);

   logic [7:0] left_ff  [fpsd_pkg::PLANES];
   logic [7:0] left_in  [fpsd_pkg::PLANES];
   logic [7:0] first_ff [fpsd_pkg::PLANES];
   logic [7:0] first_in [fpsd_pkg::PLANES];
   logic [7:0] pred     [fpsd_pkg::PLANES];
   logic [7:0] plane    [fpsd_pkg::PLANES];
   logic [7:0] delta    [fpsd_pkg::PLANES];
   logic [7:0] value    [fpsd_pkg::PLANES];
   logic       rsp_valid_ff, rsp_valid_in;
   fpsd_pkg::rsp_type rsp_ff, rsp_in;

   // The result register is free when empty or being drained this cycle.
   assign pop = pop_valid && (!rsp_valid_ff || rsp_tready);

   assign plane[fpsd_pkg::PLANE_HIGH] =
      pop_cell.item.float_bits[fpsd_pkg::HIGH_LSB +: 8] & fpsd_pkg::HIGH_MASK;
   assign plane[fpsd_pkg::PLANE_MID]  = pop_cell.item.float_bits[fpsd_pkg::MID_LSB +: 8];
   assign plane[fpsd_pkg::PLANE_LOW]  = pop_cell.item.float_bits[7:0] & fpsd_pkg::BYTE_MASK;
   assign delta[fpsd_pkg::PLANE_HIGH] = pop_cell.item.delta_high_in;
   assign delta[fpsd_pkg::PLANE_MID]  = pop_cell.item.delta_mid_in;
   assign delta[fpsd_pkg::PLANE_LOW]  = pop_cell.item.delta_low_in;

   always_comb begin
      for (int p = 0; p < fpsd_pkg::PLANES; p++) begin
         pred[p] = pop_cell.first_col ? first_ff[p] : left_ff[p];
         // Decode keeps the full byte sum as the next predictor.
         value[p] = (pop_cell.mode == fpsd_pkg::MODE_DECODE) ? pred[p] + delta[p] : plane[p];
         left_in[p]  = left_ff[p];
         first_in[p] = first_ff[p];
         if (pop) begin
            if (pop_cell.last) begin
               left_in[p]  = '0;
               first_in[p] = '0;
            end else begin
               left_in[p] = value[p];
               if (pop_cell.first_col) begin
                  first_in[p] = value[p];
               end
            end
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.tile_last = pop_cell.last;
      if (pop_cell.mode == fpsd_pkg::MODE_DECODE) begin
         rsp_in.float_out = {pop_cell.item.sign_in, pop_cell.item.exponent_in,
                             value[fpsd_pkg::PLANE_HIGH][6:0],
                             value[fpsd_pkg::PLANE_MID], value[fpsd_pkg::PLANE_LOW]};
      end else begin
         rsp_in.sign_out       = pop_cell.item.float_bits[fpsd_pkg::SIGN_BIT];
         rsp_in.exponent_out   = pop_cell.item.float_bits[fpsd_pkg::EXP_LSB +: 8];
         rsp_in.delta_high_out = value[fpsd_pkg::PLANE_HIGH] - pred[fpsd_pkg::PLANE_HIGH];
         rsp_in.delta_mid_out  = value[fpsd_pkg::PLANE_MID] - pred[fpsd_pkg::PLANE_MID];
         rsp_in.delta_low_out  = value[fpsd_pkg::PLANE_LOW] - pred[fpsd_pkg::PLANE_LOW];
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < fpsd_pkg::PLANES; p++) begin
            left_ff[p]  <= '0;
            first_ff[p] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int p = 0; p < fpsd_pkg::PLANES; p++) begin
            left_ff[p]  <= left_in[p];
            first_ff[p] <= first_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   `FPSD_ASSERT_NXT(a_tile_end_clears, clock, reset, pop && pop_cell.last,
      left_ff[0] == '0 && left_ff[1] == '0 && left_ff[2] == '0 &&
      first_ff[0] == '0 && first_ff[1] == '0 && first_ff[2] == '0)

endmodule

/* hw/rtl/float_plane_split_delta_codec_top.sv */
// Top level of the float plane split delta codec.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------------
//   req_    | in        | float bits or sign, exponent and three plane deltas
//   rsp_    | out       | rebuilt float bits or split planes, tlast = tile end
//   csr_    | in        | register index and write data, always ready
//
// One cell enters per clock while the cell queue has room. An accepted
// beat goes into the cell queue and then, once the result side is free,
// into the result register. The front stalls only when the two-entry cell
// queue is full, so a held-up result side costs nothing until the queue
// fills. Reset is synchronous and active high; it clears the tile position,
// the predictors and the registers to encode mode and one by one cells.
module float_plane_split_delta_codec_top #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // Fields from bit 0: float_bits[31:0], sign_in[32], exponent_in[40:33],
   // delta_high_in[48:41], delta_mid_in[56:49], delta_low_in[64:57], zeros.
   input  logic [fpsd_pkg::TDATA_W-1:0]    req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: float_out[31:0], sign_out[32], exponent_out[40:33],
   // delta_high_out[48:41], delta_mid_out[56:49], delta_low_out[64:57], zeros.
   output logic [fpsd_pkg::TDATA_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [fpsd_pkg::COUNT_W-1:0]    csr_data
);

   fpsd_pkg::cfg_type  cfg_ff, cfg_in;
   fpsd_pkg::item_type item;
   fpsd_pkg::cell_type push_cell, pop_cell;
   fpsd_pkg::rsp_type  rsp;
   logic               push, pop, pop_valid, queue_full;

   // The register file takes a write every cycle; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fpsd_pkg::REG_MODE:         cfg_in.mode         = csr_data[0];
            fpsd_pkg::REG_COLUMN_COUNT: cfg_in.column_count = csr_data;
            fpsd_pkg::REG_ROW_COUNT:    cfg_in.row_count    = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= fpsd_pkg::MODE_ENCODE;
         cfg_ff.column_count <= fpsd_pkg::COUNT_W'(1);
         cfg_ff.row_count    <= fpsd_pkg::COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request beat.
   assign item.float_bits    = req_tdata[31:0];
   assign item.sign_in       = req_tdata[32];
   assign item.exponent_in   = req_tdata[40:33];
   assign item.delta_high_in = req_tdata[48:41];
   assign item.delta_mid_in  = req_tdata[56:49];
   assign item.delta_low_in  = req_tdata[64:57];

   fpsd_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .item      (item),
      .queue_full(queue_full),
      .push      (push),
      .push_cell (push_cell)
   );

   fpsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cell(push_cell),
      .full     (queue_full),
      .pop      (pop),
      .pop_valid(pop_valid),
      .pop_cell (pop_cell)
   );

   fpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cell  (pop_cell),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result beat; the unused fields of the current mode are zero.
   assign rsp_tdata = {7'b0, rsp.delta_low_out, rsp.delta_mid_out, rsp.delta_high_out,
                       rsp.exponent_out, rsp.sign_out, rsp.float_out};
   assign rsp_tlast = rsp.tile_last;

endmodule

/* tb/float_plane_split_delta_codec_top_test.sv */
// Self-checking stream test of the float plane split delta codec top level.
module float_plane_split_delta_codec_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fpsd_pkg::*;

   // The tile dimensions clamp at this value; it matches the block's default.
   localparam int TILE_DIM_MAX = 4096;
   // No new random phase starts once this many cells have been accepted.
   localparam int RANDOM_CELLS = 950;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int HANG_LIMIT = 1000;
   // Quiet cycles after the last result; a request beat passes through the
   // cell queue and the result register, so these cycles show any stray result.
   localparam int SETTLE_CYCLES = 6;
   // Mismatch lines printed before the report goes quiet.
   localparam int REPORT_CAP = 50;

   // Stall styles of the result side.
   localparam int READY_ALWAYS   = 0;
   localparam int READY_COIN     = 1;
   localparam int READY_PERIODIC = 2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [TDATA_W-1:0]    req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = REG_MODE;
   logic [COUNT_W-1:0]    csr_data = '0;

   float_plane_split_delta_codec_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor of the codec. It mirrors the register file and the tile
   // walk: the left neighbour's planes, the planes of the first cell of
   // the previous row, and the position of the next cell in the tile.
   // The reset values are encode mode and a one by one tile.
   // ------------------------------------------------------------------
   logic               model_mode = MODE_ENCODE;
   logic [COUNT_W-1:0] model_columns = 1;
   logic [COUNT_W-1:0] model_rows = 1;
   logic [7:0]         left_planes [PLANES] = '{default: 8'h00};
   logic [7:0]         row_head_planes [PLANES] = '{default: 8'h00};
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;

   // Expected results in the order their request beats were accepted.
   rsp_type expected_cells [$];

   int mismatches = 0;
   int cells_sent = 0;
   int cells_checked = 0;
   int encode_cells = 0;
   int decode_cells = 0;
   int tiles_closed = 0;

   // A count of zero acts as one, anything past the maximum as the maximum.
   function automatic int unsigned clamp_count(input logic [COUNT_W-1:0] value);
      if (value == 0) return 1;
      if (value > TILE_DIM_MAX) return TILE_DIM_MAX;
      return value;
   endfunction

   // Works out the result of one cell and advances the tile walk.
   function automatic rsp_type codec_step(input item_type tile_cell);
      int unsigned cols;
      int unsigned rows;
      logic        first_col;
      logic        last_col;
      logic        tile_end;
      logic [7:0]  pred [PLANES];
      logic [7:0]  plane [PLANES];
      logic [7:0]  delta_in [PLANES];
      rsp_type     result;
      cols = clamp_count(model_columns);
      rows = clamp_count(model_rows);
      first_col = (col_pos == 0);
      // After a count shrinks mid-tile the position may already lie past
      // the new end, which still closes the row or the tile.
      last_col = (col_pos + 1 >= cols);
      tile_end = last_col && (row_pos + 1 >= rows);
      result = '0;
      delta_in[PLANE_HIGH] = tile_cell.delta_high_in;
      delta_in[PLANE_MID] = tile_cell.delta_mid_in;
      delta_in[PLANE_LOW] = tile_cell.delta_low_in;
      // The first cell of a row looks up at the previous row's first cell.
      for (int p = 0; p < PLANES; p++)
         pred[p] = first_col ? row_head_planes[p] : left_planes[p];
      if (model_mode == MODE_ENCODE) begin
         plane[PLANE_HIGH] = tile_cell.float_bits[HIGH_LSB +: 8] & HIGH_MASK;
         plane[PLANE_MID] = tile_cell.float_bits[MID_LSB +: 8];
         plane[PLANE_LOW] = tile_cell.float_bits[7:0];
         result.sign_out = tile_cell.float_bits[SIGN_BIT];
         result.exponent_out = tile_cell.float_bits[EXP_LSB +: 8];
         result.delta_high_out = plane[PLANE_HIGH] - pred[PLANE_HIGH];
         result.delta_mid_out = plane[PLANE_MID] - pred[PLANE_MID];
         result.delta_low_out = plane[PLANE_LOW] - pred[PLANE_LOW];
      end else begin
         // The decoder keeps the full byte sums as predictors; only the
         // rebuilt pattern sees the high plane cut to seven bits.
         for (int p = 0; p < PLANES; p++)
            plane[p] = pred[p] + delta_in[p];
         result.float_out = {tile_cell.sign_in, tile_cell.exponent_in,
                             plane[PLANE_HIGH][6:0], plane[PLANE_MID],
                             plane[PLANE_LOW]};
      end
      result.tile_last = tile_end;
      for (int p = 0; p < PLANES; p++) begin
         left_planes[p] = plane[p];
         if (first_col) row_head_planes[p] = plane[p];
      end
      if (tile_end) begin
         // The end of a tile wipes every predictor and the position.
         left_planes = '{default: 8'h00};
         row_head_planes = '{default: 8'h00};
         col_pos = 0;
         row_pos = 0;
      end else if (last_col) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
      return result;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Beats go out in bursts of random length separated by
   // random gaps; a phase may also run with the sender never pausing.
   // ------------------------------------------------------------------
   int burst_left = 0;
   bit steady_sender = 1'b0;

   function automatic item_type make_cell(input logic [31:0] bits, input logic sign,
                                          input logic [7:0] exponent,
                                          input logic [7:0] high, input logic [7:0] mid,
                                          input logic [7:0] low);
      item_type tile_cell;
      tile_cell.float_bits = bits;
      tile_cell.sign_in = sign;
      tile_cell.exponent_in = exponent;
      tile_cell.delta_high_in = high;
      tile_cell.delta_mid_in = mid;
      tile_cell.delta_low_in = low;
      return tile_cell;
   endfunction

   // Called just after a rising edge; returns at the edge that took the beat.
   task automatic send_cell(input item_type tile_cell);
      int gap;
      if (burst_left == 0) begin
         burst_left = steady_sender ? 1000 : $urandom_range(1, 16);
         gap = steady_sender ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= {7'b0, tile_cell.delta_low_in, tile_cell.delta_mid_in,
                    tile_cell.delta_high_in, tile_cell.exponent_in, tile_cell.sign_in,
                    tile_cell.float_bits};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (model_mode == MODE_ENCODE) encode_cells++;
      else decode_cells++;
      expected_cells.push_back(codec_step(tile_cell));
      cells_sent++;
   endtask

   // Stops the request side and waits until every result has come back.
   // Every cell yields exactly one result, so an empty queue plus a few
   // quiet cycles means the block is idle and may be reconfigured.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register beat on the configuration channel; the predictor's copy
   // changes at the edge that takes the beat.
   task automatic write_register(input logic [1:0] index, input logic [COUNT_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_MODE:         model_mode = value[0];
         REG_COLUMN_COUNT: model_columns = value;
         REG_ROW_COUNT:    model_rows = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side. The ready line follows a style that a tick counter redraws
   // at random: always ready, a coin toss per cycle, or a fixed period with
   // one stalled cycle in each. Each result beat is checked against the
   // oldest expectation, field by field.
   // ------------------------------------------------------------------
   int stall_style = READY_ALWAYS;
   int stall_period = 3;
   int stall_tick = 0;

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         if (mismatches < REPORT_CAP)
            $display("%0t ns: cell %0d %s expected 0x%0h actual 0x%0h",
                     $time, cells_checked, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cells.size() == 0) begin
            if (mismatches < REPORT_CAP)
               $display("%0t ns: result beat with no cell waiting, expected none actual 0x%0h",
                        $time, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            compare_field("float_out", want.float_out, rsp_tdata[31:0]);
            compare_field("sign_out", want.sign_out, rsp_tdata[32]);
            compare_field("exponent_out", want.exponent_out, rsp_tdata[40:33]);
            compare_field("delta_high_out", want.delta_high_out, rsp_tdata[48:41]);
            compare_field("delta_mid_out", want.delta_mid_out, rsp_tdata[56:49]);
            compare_field("delta_low_out", want.delta_low_out, rsp_tdata[64:57]);
            compare_field("tile_last", want.tile_last, rsp_tlast);
            if (want.tile_last) tiles_closed++;
            cells_checked++;
         end
      end
      stall_tick++;
      if (stall_tick % 48 == 0) begin
         stall_style = $urandom_range(READY_ALWAYS, READY_PERIODIC);
         stall_period = $urandom_range(2, 7);
      end
      case (stall_style)
         READY_COIN:     rsp_tready <= $urandom_range(0, 1);
         READY_PERIODIC: rsp_tready <= (stall_tick % stall_period) != 0;
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // ------------------------------------------------------------------
   // Hang detection: any cycle that moves a beat on any channel clears the
   // count. The longest honest pause is a sender gap, a drain, a register
   // write or a run of receiver stalls, all far below the limit.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles, %0d results still due",
                  $time, HANG_LIMIT, expected_cells.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------

   // Out of reset the tile is a single cell, so every cell closes a tile,
   // the predictors stay at zero and the deltas equal the planes.
   task automatic test_power_on_tile();
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_cell(make_cell(32'h8000_0000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h7F80_0000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h007F_FFFF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // Three by two encode tile: left prediction along a row, the second
   // row's first cell predicted from the first row's first cell, and
   // deltas that wrap below zero.
   task automatic test_encode_tile_walk();
      wait_for_drain();
      write_register(REG_COLUMN_COUNT, 3);
      write_register(REG_ROW_COUNT, 2);
      send_cell(make_cell(32'h3F80_0000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h3F80_0001, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h3F7F_FFFF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h4049_0FDB, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'hC049_0FDB, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // The same shape in decode mode. A high delta of 0xFF leaves a full
   // byte as predictor while the rebuilt pattern shows only seven bits;
   // the following cell's sum then wraps through zero.
   task automatic test_decode_tile_walk();
      wait_for_drain();
      write_register(REG_MODE, MODE_DECODE);
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF));
      send_cell(make_cell(32'hFFFF_FFFF, 1'b1, 8'hFF, 8'h01, 8'h01, 8'h01));
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h7F, 8'h80, 8'h7F, 8'h80));
      send_cell(make_cell(32'h0000_0000, 1'b1, 8'h80, 8'h7F, 8'h00, 8'hFE));
      send_cell(make_cell(32'hFFFF_FFFF, 1'b0, 8'h01, 8'h00, 8'h80, 8'h00));
      send_cell(make_cell(32'h0000_0000, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'h01));
   endtask

   // A column count of zero behaves as one and a row count past the limit
   // as the limit, so each cell starts a new row below the last.
   task automatic test_count_clamping();
      wait_for_drain();
      write_register(REG_MODE, MODE_ENCODE);
      write_register(REG_COLUMN_COUNT, 0);
      write_register(REG_ROW_COUNT, 13'h1FFF);
      send_cell(make_cell(32'h1234_5678, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h8765_4321, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_cell(make_cell(32'h00FF_00FF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // Inside the still open tile: switch to decode so the encoder's planes
   // feed the decoder, widen the rows, then shrink both counts below the
   // current position so the next cell closes the tile.
   task automatic test_mid_tile_reconfig();
      wait_for_drain();
      write_register(REG_MODE, MODE_DECODE);
      write_register(REG_COLUMN_COUNT, 4);
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h3C, 8'h10, 8'h20, 8'h30));
      send_cell(make_cell(32'h0000_0000, 1'b1, 8'hC3, 8'hF0, 8'hE0, 8'hD0));
      wait_for_drain();
      write_register(REG_COLUMN_COUNT, 1);
      write_register(REG_ROW_COUNT, 0);
      send_cell(make_cell(32'h0000_0000, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA));
   endtask

   // ------------------------------------------------------------------
   // Random tiles: each phase reprograms some registers while idle and then
   // streams a run of cells. Counts are mostly small so tiles close often;
   // now and then they sit at zero, the limit or past it.
   // ------------------------------------------------------------------
   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 15))
         0:       return 0;
         1:       return TILE_DIM_MAX;
         2:       return TILE_DIM_MAX + 1;
         3:       return 13'h1FFF;
         4:       return $urandom_range(0, 13'h1FFF);
         5:       return TILE_DIM_MAX - 1;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic test_random_tiles();
      int          start_count;
      int          run_length;
      logic [31:0] bits;
      start_count = cells_sent;
      while (cells_sent - start_count < RANDOM_CELLS) begin
         wait_for_drain();
         steady_sender = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0)
            write_register(REG_MODE, $urandom_range(MODE_ENCODE, MODE_DECODE));
         if ($urandom_range(0, 2) != 0) write_register(REG_COLUMN_COUNT, pick_count());
         if ($urandom_range(0, 2) != 0) write_register(REG_ROW_COUNT, pick_count());
         run_length = $urandom_range(10, 60);
         repeat (run_length) begin
            case ($urandom_range(0, 11))
               0:       bits = 32'h0000_0000;
               1:       bits = 32'hFFFF_FFFF;
               2:       bits = 32'h7FC0_0000;
               3:       bits = 32'h0000_0001;
               4:       bits = {1'($urandom_range(0, 1)), 8'hFF, 23'h0};
               default: bits = $urandom;
            endcase
            send_cell(make_cell(bits, $urandom_range(0, 1), pick_byte(), pick_byte(),
                                pick_byte(), pick_byte()));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_tile();
      test_encode_tile_walk();
      test_decode_tile_walk();
      test_count_clamping();
      test_mid_tile_reconfig();
      test_random_tiles();
      wait_for_drain();
      $display("Checked %0d cells (%0d encoded, %0d decoded) closing %0d tiles,",
               cells_checked, encode_cells, decode_cells, tiles_closed);
      $display("with clamped counts, mid-tile register writes and stalls on both sides.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
